@@ src/button_click_long_press_detector_assert.svh @@
// Assertion macros shared by the detector's checker.
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH

// Check on every clock edge outside reset.
`define BCLPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define BCLPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/bclpd_pkg.sv @@
// Types, codes and defaults of the button click and long press detector.
package bclpd_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned CfgWidth         = 16;
  localparam int unsigned DurWidth         = 32;
  localparam int unsigned EventWidth       = 3;
  localparam int unsigned ClickWidth       = 3;

  localparam logic                ActiveLowReset   = 1'b1;
  localparam logic [CfgWidth-1:0] DebounceReset    = 16'd20;
  localparam logic [CfgWidth-1:0] LongPressReset   = 16'd800;
  localparam logic [CfgWidth-1:0] DoubleClickReset = 16'd300;

  localparam logic [ClickWidth-1:0] ClickMax = 3'd7;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_LONG     = 3'd3,
    EV_SINGLE   = 3'd4,
    EV_DOUBLE   = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    REG_ACTIVE_LOW   = 2'd0,
    REG_DEBOUNCE     = 2'd1,
    REG_LONG_PRESS   = 2'd2,
    REG_DOUBLE_CLICK = 2'd3
  } cfg_idx_e;

endpackage

@@ src/button_click_long_press_detector.sv @@
// Button debounce, press/release, long press and click detector.
//
// One input item is one millisecond tick carrying the raw pin level on
// raw_level_i. Every accepted item yields exactly one result item with
// event_res_o, is_held_o and held_duration_o.
// Input handshake: an item is taken at a clock edge with in_valid_i high and
// in_stall_o low. Output handshake: a result is taken at an edge with
// out_valid_o high and out_stall_i low.
// The result of an item taken at one edge shows in the output register after
// that edge. Throughput is one item per cycle; the single output register
// sets it, and in_stall_o rises only while a result sits in that register
// and the receiver stalls it.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
// next edge and are expected only while the block is idle.
// Reset (rst_ni low, asynchronous) clears time, debounce and click state,
// drops any pending result and loads the default register values.
module button_click_long_press_detector
  import bclpd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CfgWidth-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  raw_level_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [EventWidth-1:0] event_res_o,
  output logic                  is_held_o,
  output logic [DurWidth-1:0]   held_duration_o
);

  typedef logic [TIME_WIDTH-1:0] time_t;

  logic                active_low_q;
  logic [CfgWidth-1:0] debounce_q, long_press_q, double_click_q;

  time_t                 time_q, last_chg_q, press_time_q, release_time_q;
  time_t                 last_chg_d, press_time_d, release_time_d;
  logic                  last_raw_q, pressed_q, long_fired_q;
  logic                  pressed_d, long_fired_d;
  logic [ClickWidth-1:0] clicks_q, clicks_d;

  logic                out_valid_q;
  event_e              event_q, event_d;
  logic                held_q;
  logic [DurWidth-1:0] dur_q, dur_d;

  logic  in_accept, lvl, stable;
  time_t press_diff, release_diff;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q   <= ActiveLowReset;
      debounce_q     <= DebounceReset;
      long_press_q   <= LongPressReset;
      double_click_q <= DoubleClickReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACTIVE_LOW:   active_low_q   <= cfg_data_i[0];
        REG_DEBOUNCE:     debounce_q     <= cfg_data_i;
        REG_LONG_PRESS:   long_press_q   <= cfg_data_i;
        REG_DOUBLE_CLICK: double_click_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  always_comb begin
    lvl          = raw_level_i ^ active_low_q;
    last_chg_d   = (lvl != last_raw_q) ? time_q : last_chg_q;
    stable       = (time_q - last_chg_d) >= TIME_WIDTH'(debounce_q);
    press_diff   = time_q - press_time_q;
    release_diff = time_q - release_time_q;

    pressed_d      = pressed_q;
    long_fired_d   = long_fired_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    clicks_d       = clicks_q;
    event_d        = EV_NONE;

    // Press edge, then release edge, then long press, then click resolution.
    if (stable) begin
      priority if (lvl && !pressed_q) begin
        pressed_d    = 1'b1;
        press_time_d = time_q;
        long_fired_d = 1'b0;
        event_d      = EV_PRESSED;
      end else if (!lvl && pressed_q) begin
        pressed_d      = 1'b0;
        release_time_d = time_q;
        if (!long_fired_q && clicks_q != ClickMax) begin
          clicks_d = clicks_q + ClickWidth'(1);
        end
        event_d = EV_RELEASED;
      end else if (pressed_q && !long_fired_q &&
                   press_diff >= TIME_WIDTH'(long_press_q)) begin
        long_fired_d = 1'b1;
        clicks_d     = '0;
        event_d      = EV_LONG;
      end else if (!pressed_q && clicks_q != '0 &&
                   release_diff >= TIME_WIDTH'(double_click_q)) begin
        event_d  = (clicks_q == ClickWidth'(1)) ? EV_SINGLE : EV_DOUBLE;
        clicks_d = '0;
      end else begin
      end
    end

    dur_d = pressed_d ? DurWidth'(time_t'(time_q - press_time_d)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q         <= '0;
      last_raw_q     <= 1'b0;
      last_chg_q     <= '0;
      pressed_q      <= 1'b0;
      long_fired_q   <= 1'b0;
      press_time_q   <= '0;
      release_time_q <= '0;
      clicks_q       <= '0;
    end else if (in_accept) begin
      time_q         <= time_q + time_t'(1);
      last_raw_q     <= lvl;
      last_chg_q     <= last_chg_d;
      pressed_q      <= pressed_d;
      long_fired_q   <= long_fired_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      clicks_q       <= clicks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_accept;
    end
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      event_q <= event_d;
      held_q  <= pressed_d;
      dur_q   <= dur_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = event_q;
  assign is_held_o       = held_q;
  assign held_duration_o = dur_q;

endmodule

@@ src/bclpd_checker.sv @@
// Port-level checker for the detector, bound to the top level.
`include "button_click_long_press_detector_assert.svh"

module bclpd_checker
  import bclpd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [EventWidth-1:0] event_res_o,
  input logic                  is_held_o,
  input logic [DurWidth-1:0]   held_duration_o
);

  `BCLPD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `BCLPD_ASSERT(a_accept_result, in_valid_i && !in_stall_o |=> out_valid_o, "accepted item gave no result")
  `BCLPD_ASSERT(a_stall_pending, in_stall_o |-> out_valid_o, "input stalled with no pending result")
  `BCLPD_ASSERT(a_press_zero, out_valid_o && event_res_o == EV_PRESSED |-> is_held_o && held_duration_o == '0, "press result not held at zero duration")
  `BCLPD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> out_valid_o !== 1'b1, "result valid during reset")

endmodule

bind button_click_long_press_detector bclpd_checker u_bclpd_checker (.*);
